/* rtl/olrx_pkg.sv */
package olrx_pkg;

    // Field widths of one word
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned LEVEL_W   = 8;
    localparam int unsigned PAYLOAD_W = 32;
    localparam int unsigned REQ_W     = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CHECK  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // Expiry limit after reset
    localparam logic [TIME_W-1:0] EXPIRE_RESET = 32'd30000;

    // One ring entry as held in memory
    typedef struct packed {
        logic [TIME_W-1:0]    stamp;
        logic [LEVEL_W-1:0]   level;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

/* rtl/olrx_ram.sv */
module olrx_ram #(
    parameter int unsigned WIDTH = 72,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/overwriting_log_ring_with_expiry_core.sv */
// Channel  | Handshake           | Word
// ---------+---------------------+-----------------------------------------------
// request  | start, busy         | req_type, now_time, in_level, in_payload, is_blank
// result   | done (one cycle)    | accepted, out_time, out_level, out_payload,
//          |                     | more_available, reading_active
// config   | cfg_we              | cfg_wdata (expiry limit)
//
// Push, blank push and unused codes: result in the cycle after acceptance, busy stays low.
// Pop: passes through ST_POP, waiting on the registered read of the entry memory.
// Check: stays in ST_SCAN and drops expired entries from the head (at most RING_DEPTH);
// each drop waits on one memory read of the next head entry.
// Reset clears pointers, fill flag and last read time, and sets the limit to EXPIRE_RESET; memory is not cleared.
// The receiver cannot stall: done is high for exactly one cycle per word.
module overwriting_log_ring_with_expiry_core
    import olrx_pkg::*;
#(
    parameter int unsigned RING_DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [TIME_W-1:0]    now_time,
    input  logic [LEVEL_W-1:0]   in_level,
    input  logic [PAYLOAD_W-1:0] in_payload,
    input  logic                 is_blank,
    input  logic                 cfg_we,
    input  logic [TIME_W-1:0]    cfg_wdata,
    output logic                 done,
    output logic                 accepted,
    output logic [TIME_W-1:0]    out_time,
    output logic [LEVEL_W-1:0]   out_level,
    output logic [PAYLOAD_W-1:0] out_payload,
    output logic                 more_available,
    output logic                 reading_active
);

    localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN
    } state_t;

    state_t               state_reg, state_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic                 full_reg, full_next;
    logic [TIME_W-1:0]    last_read_reg, last_read_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [TIME_W-1:0]    expire_reg;
    logic                 done_reg, done_next;
    logic                 accepted_reg, accepted_next;
    logic [TIME_W-1:0]    out_time_reg, out_time_next;
    logic [LEVEL_W-1:0]   out_level_reg, out_level_next;
    logic [PAYLOAD_W-1:0] out_payload_reg, out_payload_next;
    logic                 more_reg, more_next;
    logic                 active_reg, active_next;

    logic                 ring_empty;
    logic [PTR_W-1:0]     head_adv;
    logic [PTR_W-1:0]     tail_adv;
    logic                 mem_we;
    entry_t               wr_entry;
    entry_t               rd_entry;
    logic [TIME_W-1:0]    entry_age;
    logic [TIME_W-1:0]    read_age;
    logic                 head_expired;

    // Ring status and pointer steps
    assign ring_empty = !full_reg && (head_reg == tail_reg);
    assign head_adv   = (head_reg == LAST_IDX) ? '0 : head_reg + PTR_W'(1);
    assign tail_adv   = (tail_reg == LAST_IDX) ? '0 : tail_reg + PTR_W'(1);

    // Ages, wrapping
    assign entry_age    = now_reg - rd_entry.stamp;
    assign read_age     = now_reg - last_read_reg;
    assign head_expired = (entry_age >= expire_reg);

    // Push writes straight into memory on acceptance
    assign mem_we           = (state_reg == ST_IDLE) && start
                              && (req_type == REQ_PUSH) && !is_blank;
    assign wr_entry.stamp   = now_time;
    assign wr_entry.level   = in_level;
    assign wr_entry.payload = in_payload;

    // Read address follows the next head, so the head entry is ready in the next cycle
    olrx_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (tail_reg),
        .wdata (wr_entry),
        .raddr (head_next),
        .rdata (rd_entry)
    );

    // Sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        full_next        = full_reg;
        last_read_next   = last_read_reg;
        now_next         = now_reg;
        done_next        = 1'b0;
        accepted_next    = 1'b0;
        out_time_next    = '0;
        out_level_next   = '0;
        out_payload_next = '0;
        more_next        = 1'b0;
        active_next      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        REQ_PUSH:
                        begin
                            done_next = 1'b1;
                            if (!is_blank)
                            begin
                                accepted_next = 1'b1;
                                tail_next     = tail_adv;
                                // full ring: oldest entry is overwritten
                                if (full_reg)
                                begin
                                    head_next = head_adv;
                                    full_next = 1'b1;
                                end
                                else
                                begin
                                    full_next = (tail_adv == head_reg);
                                end
                            end
                        end
                        REQ_POP:
                        begin
                            last_read_next = now_time;
                            state_next     = ST_POP;
                        end
                        REQ_CHECK:
                        begin
                            now_next   = now_time;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_POP:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (!ring_empty)
                begin
                    accepted_next    = 1'b1;
                    out_time_next    = rd_entry.stamp;
                    out_level_next   = rd_entry.level;
                    out_payload_next = rd_entry.payload;
                    head_next        = head_adv;
                    full_next        = 1'b0;
                    more_next        = (head_adv != tail_reg);
                end
            end

            ST_SCAN:
            begin
                // drop one expired head entry per cycle
                if (!ring_empty && head_expired)
                begin
                    head_next = head_adv;
                    full_next = 1'b0;
                end
                else
                begin
                    done_next   = 1'b1;
                    active_next = (read_age < expire_reg);
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            full_reg      <= 1'b0;
            last_read_reg <= '0;
            expire_reg    <= EXPIRE_RESET;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            full_reg      <= full_next;
            last_read_reg <= last_read_next;
            done_reg      <= done_next;
            if (cfg_we)
            begin
                expire_reg <= cfg_wdata;
            end
        end
    end

    // Result word and sampled tick
    always_ff @(posedge clk)
    begin
        now_reg         <= now_next;
        accepted_reg    <= accepted_next;
        out_time_reg    <= out_time_next;
        out_level_reg   <= out_level_next;
        out_payload_reg <= out_payload_next;
        more_reg        <= more_next;
        active_reg      <= active_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign accepted       = accepted_reg;
    assign out_time       = out_time_reg;
    assign out_level      = out_level_reg;
    assign out_payload    = out_payload_reg;
    assign more_available = more_reg;
    assign reading_active = active_reg;

endmodule

/* rtl/olrx_checker.sv */
module olrx_checker
    import olrx_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic [REQ_W-1:0]     req_type,
    input logic                 done,
    input logic                 accepted,
    input logic [TIME_W-1:0]    out_time,
    input logic [LEVEL_W-1:0]   out_level,
    input logic [PAYLOAD_W-1:0] out_payload,
    input logic                 more_available,
    input logic                 reading_active
);

    // Push and unused codes answer in the next cycle
    a_push_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_PUSH || req_type == REQ_UNUSED)) |=> done)
        else $error("push word not answered in one cycle");

    // Pop waits one memory read, then answers
    a_pop_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_POP) |=> (busy ##1 done))
        else $error("pop word not answered in two cycles");

    // A result word only ever leaves an idle block
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while still busy");

    // Accept and activity flags belong to different requests
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(accepted && reading_active))
        else $error("accepted and reading_active together");

    // Entry fields are zero unless an entry was returned
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !accepted) |->
            (out_time == '0 && out_level == '0 && out_payload == '0 && !more_available))
        else $error("entry fields set without an entry");

endmodule

bind overwriting_log_ring_with_expiry_core olrx_checker u_olrx_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .done           (done),
    .accepted       (accepted),
    .out_time       (out_time),
    .out_level      (out_level),
    .out_payload    (out_payload),
    .more_available (more_available),
    .reading_active (reading_active)
);

/* bench/overwriting_log_ring_with_expiry_core_tb.sv */
module overwriting_log_ring_with_expiry_core_tb;
    import olrx_pkg::*;

    localparam int unsigned DEPTH       = 16;
    localparam int unsigned SETTLE      = 2 * DEPTH + 4;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // Request word as queued for the driver
    typedef struct packed {
        logic [REQ_W-1:0]     req;
        logic [TIME_W-1:0]    now;
        logic [LEVEL_W-1:0]   level;
        logic [PAYLOAD_W-1:0] payload;
        logic                 blank;
    } req_word_t;

    // Result word as predicted
    typedef struct packed {
        logic                 accepted;
        logic [TIME_W-1:0]    out_time;
        logic [LEVEL_W-1:0]   out_level;
        logic [PAYLOAD_W-1:0] out_payload;
        logic                 more_available;
        logic                 reading_active;
    } result_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [REQ_W-1:0]     req_type = REQ_PUSH;
    logic [TIME_W-1:0]    now_time = '0;
    logic [LEVEL_W-1:0]   in_level = '0;
    logic [PAYLOAD_W-1:0] in_payload = '0;
    logic                 is_blank = 1'b0;
    logic                 cfg_we;
    logic [TIME_W-1:0]    cfg_wdata;
    logic                 done;
    logic                 accepted;
    logic [TIME_W-1:0]    out_time;
    logic [LEVEL_W-1:0]   out_level;
    logic [PAYLOAD_W-1:0] out_payload;
    logic                 more_available;
    logic                 reading_active;

    overwriting_log_ring_with_expiry_core #(
        .RING_DEPTH (DEPTH)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .now_time       (now_time),
        .in_level       (in_level),
        .in_payload     (in_payload),
        .is_blank       (is_blank),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .done           (done),
        .accepted       (accepted),
        .out_time       (out_time),
        .out_level      (out_level),
        .out_payload    (out_payload),
        .more_available (more_available),
        .reading_active (reading_active)
    );

    // Clock, period 10
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Words waiting to go out, and results still owed
    req_word_t    pending_words[$];
    result_word_t owed_results[$];

    int unsigned idle_pct = 0;
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_fail = 0;
    int unsigned n_overwrites = 0;
    int unsigned n_expired = 0;
    int unsigned n_settings = 0;
    int unsigned n_cycles = 0;
    logic [TIME_W-1:0] gen_now = '0;

    // Shadow of the ring
    entry_t            ring_mem[DEPTH];
    int unsigned       head_ptr = 0;
    int unsigned       tail_ptr = 0;
    bit                ring_full = 1'b0;
    logic [TIME_W-1:0] last_read = '0;
    logic [TIME_W-1:0] expire_lim = EXPIRE_RESET;

    function automatic int unsigned ring_next(input int unsigned p);
        return (p + 1 >= DEPTH) ? 0 : p + 1;
    endfunction

    function automatic bit ring_is_empty();
        return !ring_full && (head_ptr == tail_ptr);
    endfunction

    function automatic void ring_drop_head();
        if (!ring_is_empty())
        begin
            ring_full = 1'b0;
            ring_mem[head_ptr] = '0;
            head_ptr = ring_next(head_ptr);
        end
    endfunction

    // Apply one word to the shadow ring and give the result it should produce
    function automatic result_word_t ring_apply(input req_word_t w);
        result_word_t      r;
        logic [TIME_W-1:0] age;
        bit                scanning;
        int unsigned       n;
        r = '0;
        case (w.req)
            REQ_PUSH:
            begin
                if (!w.blank)
                begin
                    ring_mem[tail_ptr].stamp   = w.now;
                    ring_mem[tail_ptr].level   = w.level;
                    ring_mem[tail_ptr].payload = w.payload;
                    if (ring_full)
                    begin
                        head_ptr = ring_next(head_ptr);
                        n_overwrites++;
                    end
                    tail_ptr  = ring_next(tail_ptr);
                    ring_full = (tail_ptr == head_ptr);
                    r.accepted = 1'b1;
                end
            end
            REQ_POP:
            begin
                last_read = w.now;
                if (!ring_is_empty())
                begin
                    r.accepted    = 1'b1;
                    r.out_time    = ring_mem[head_ptr].stamp;
                    r.out_level   = ring_mem[head_ptr].level;
                    r.out_payload = ring_mem[head_ptr].payload;
                    ring_drop_head();
                    r.more_available = !ring_is_empty();
                end
            end
            REQ_CHECK:
            begin
                // drop aged entries from the head, at most the depth
                scanning = 1'b1;
                n = 0;
                while (scanning && n < DEPTH && !ring_is_empty())
                begin
                    age = w.now - ring_mem[head_ptr].stamp;
                    if (age < expire_lim)
                        scanning = 1'b0;
                    else
                    begin
                        ring_drop_head();
                        n_expired++;
                        n++;
                    end
                end
                age = w.now - last_read;
                r.reading_active = (age < expire_lim);
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Driver: predict on acceptance, then offer the next word or idle
    always @(posedge clk)
    begin : drive
        req_word_t w;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                owed_results.push_back(ring_apply(w));
                n_sent++;
            end
            if (!start || !busy)
            begin
                if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    w = pending_words.pop_front();
                    start      <= 1'b1;
                    req_type   <= w.req;
                    now_time   <= w.now;
                    in_level   <= w.level;
                    in_payload <= w.payload;
                    is_blank   <= w.blank;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endfunction

    // Monitor: each strobed word against the oldest owed result
    always @(posedge clk)
    begin : watch
        result_word_t want;
        if (rst_n && done)
        begin
            if (owed_results.size() == 0)
            begin
                $error("result word with nothing owed");
                n_fail++;
            end
            else
            begin
                want = owed_results.pop_front();
                check_field("accepted", 32'(want.accepted), 32'(accepted));
                check_field("out_time", want.out_time, out_time);
                check_field("out_level", 32'(want.out_level), 32'(out_level));
                check_field("out_payload", want.out_payload, out_payload);
                check_field("more_available", 32'(want.more_available),
                            32'(more_available));
                check_field("reading_active", 32'(want.reading_active),
                            32'(reading_active));
                n_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("overwriting_log_ring_with_expiry_core_tb NOT OK");
            $finish;
        end
    end

    task automatic queue_word(input logic [REQ_W-1:0] req, input logic [TIME_W-1:0] now,
                              input logic [LEVEL_W-1:0] level,
                              input logic [PAYLOAD_W-1:0] payload, input logic blank);
        req_word_t w;
        w.req     = req;
        w.now     = now;
        w.level   = level;
        w.payload = payload;
        w.blank   = blank;
        pending_words.push_back(w);
    endtask

    // Random words in bursts that lean towards filling or draining the ring
    task automatic queue_random(input int unsigned count);
        req_word_t         w;
        int unsigned       k;
        int unsigned       burst;
        int unsigned       push_pct;
        int unsigned       r;
        logic [TIME_W-1:0] lim;
        logic [TIME_W-1:0] gap;
        burst = 0;
        push_pct = 50;
        for (k = 0; k < count; k++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(8, 24);
                push_pct = ($urandom_range(0, 1) == 0) ? 75 : 30;
            end
            burst--;
            // time steps scaled to the limit, with the odd wild jump
            lim = (expire_lim > 32'd100000) ? 32'd100000 : expire_lim;
            if (lim < 8)
                lim = 8;
            r = $urandom_range(0, 99);
            if (r < 3)
                gap = $urandom;
            else if (r < 20)
                gap = '0;
            else if (r < 30)
                gap = $urandom_range(lim / 2, lim + lim / 2);
            else
                gap = $urandom_range(0, lim / 6);
            gen_now  = gen_now + gap;
            w.now     = gen_now;
            w.level   = LEVEL_W'($urandom_range(0, 255));
            w.payload = $urandom;
            w.blank   = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 99);
            if (r < push_pct)
            begin
                w.req   = REQ_PUSH;
                w.blank = 1'b0;
            end
            else if (r < 94)
                w.req = ($urandom_range(0, 2) == 0) ? REQ_CHECK : REQ_POP;
            else if (r < 97)
            begin
                w.req   = REQ_PUSH;
                w.blank = 1'b1;
            end
            else
                w.req = REQ_UNUSED;
            pending_words.push_back(w);
        end
    endtask

    // Wait until everything sent has come back, then let the core settle
    task automatic wait_drain();
        @(negedge clk);
        while (pending_words.size() != 0 || start || owed_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_limit(input logic [TIME_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        expire_lim = v;
        n_settings++;
    endtask

    task automatic run_phase(input logic [TIME_W-1:0] lim, input int unsigned pct,
                             input int unsigned count);
        write_limit(lim);
        @(negedge clk);
        idle_pct = pct;
        queue_random(count);
        wait_drain();
    endtask

    // Sequence of phases
    initial
    begin : sequencer
        int unsigned i;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idle_pct = 8;

        // directed: empty ring, blank and unused words, wrap of stamps, overwrite,
        // partial expiry, pops, full expiry with reader gone quiet
        queue_word(REQ_POP, 32'd0, 8'h00, 32'h0, 1'b0);
        queue_word(REQ_CHECK, 32'd5, 8'h00, 32'h0, 1'b1);
        queue_word(REQ_PUSH, 32'd10, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        queue_word(REQ_UNUSED, $urandom, LEVEL_W'($urandom_range(0, 255)), $urandom, 1'b1);
        queue_word(REQ_PUSH, 32'hFFFF_FFF0, 8'h00, 32'h0000_0000, 1'b0);
        queue_word(REQ_PUSH, 32'hFFFF_FFF8, 8'hFF, 32'hFFFF_FFFF, 1'b0);
        for (i = 0; i < 15; i++)
            queue_word(REQ_PUSH, i * 100, LEVEL_W'($urandom_range(0, 255)), $urandom, 1'b0);
        queue_word(REQ_CHECK, 32'd30550, 8'h00, 32'h0, 1'b0);
        queue_word(REQ_POP, 32'd30600, 8'h00, 32'h0, 1'b0);
        queue_word(REQ_POP, 32'd30601, 8'h00, 32'h0, 1'b0);
        queue_word(REQ_CHECK, 32'd60601, 8'h00, 32'h0, 1'b0);
        gen_now = 32'd60601;
        wait_drain();

        // random phases over several limits, extremes included
        run_phase(32'd1, 8, 150);
        run_phase(32'd0, 8, 30);
        run_phase(32'hFFFF_FFFF, 83, 150);
        run_phase(32'd200, 83, 300);
        run_phase(32'd30000, 0, 350);
        run_phase($urandom_range(2, 5000), 0, 300);

        $display("Covered %0d words under %0d expiry limits, with sparse, heavy and no idling",
                 n_sent, n_settings);
        $display("%0d results checked; %0d oldest entries overwritten, %0d entries expired",
                 n_checked, n_overwrites, n_expired);
        if (n_fail == 0)
            $display("overwriting_log_ring_with_expiry_core_tb OK");
        else
            $display("overwriting_log_ring_with_expiry_core_tb NOT OK");
        $finish;
    end

endmodule

/* files.f */
rtl/olrx_pkg.sv
rtl/olrx_ram.sv
rtl/overwriting_log_ring_with_expiry_core.sv
rtl/olrx_checker.sv
bench/overwriting_log_ring_with_expiry_core_tb.sv
